[rtl/assert_macros.svh]
// assertion macros shared by the hopping unit modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every clock edge outside reset
`define RSGH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// condition followed by a consequence in the next cycle
`define RSGH_ASSERT_NEXT(lbl, pre, post, msg) \
    `RSGH_ASSERT(lbl, (pre) |=> (post), msg)

`endif

[rtl/ul_rsgh_pkg.sv]
// types, constants and register codes of the uplink rs group/sequence hopping unit
package ul_rsgh_pkg;

    localparam int SLOTS      = 20;
    localparam int GROUPS     = 30;
    localparam int GOLD_LEN   = 31;
    localparam int WARMUP     = 1600;
    localparam int WARM_STEPS = WARMUP - GOLD_LEN;

    localparam int SLOT_W = 5;
    localparam int ID_W   = 9;
    localparam int OUT_W  = 5;
    localparam int NS_W   = $clog2(SLOTS);
    // reduction unit: operand holds any identity, modulus holds SLOTS or GROUPS
    localparam int VAL_W  = 9;
    localparam int MOD_W  = 6;
    localparam int QUOT_W = 6;
    localparam int CNT_W  = 11;

    localparam logic [GOLD_LEN-1:0] X1_INIT = 31'h54D21B24;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        REG_CELL_ID   = 3'd0,
        REG_CTRL_ID   = 3'd1,
        REG_SHARED_ID = 3'd2,
        REG_ID_SRC    = 3'd3,
        REG_SHIFT_OFS = 3'd4,
        REG_GHOP_EN   = 3'd5,
        REG_SHOP_EN   = 3'd6,
        REG_LONG_SEQ  = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        SRC_CELL   = 2'd0,
        SRC_CTRL   = 2'd1,
        SRC_SHARED = 2'd2
    } t_id_src;

    typedef struct packed {
        logic [ID_W-1:0] cell_id;
        logic [ID_W-1:0] ctrl_id;
        logic [ID_W-1:0] shared_id;
        logic [1:0]      id_src;
        logic [4:0]      shift_ofs;
        logic            ghop_en;
        logic            shop_en;
        logic            long_seq;
    } t_cfg;

endpackage

[rtl/ul_rsgh_cfg.sv]
// apb configuration registers of the hopping unit
module ul_rsgh_cfg
    import ul_rsgh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[4:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (idx)
                REG_CELL_ID:   n_cfg.cell_id   = pwdata[ID_W-1:0];
                REG_CTRL_ID:   n_cfg.ctrl_id   = pwdata[ID_W-1:0];
                REG_SHARED_ID: n_cfg.shared_id = pwdata[ID_W-1:0];
                REG_ID_SRC:    n_cfg.id_src    = pwdata[1:0];
                REG_SHIFT_OFS: n_cfg.shift_ofs = pwdata[4:0];
                REG_GHOP_EN:   n_cfg.ghop_en   = pwdata[0];
                REG_SHOP_EN:   n_cfg.shop_en   = pwdata[0];
                REG_LONG_SEQ:  n_cfg.long_seq  = pwdata[0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_CELL_ID:   prdata = DATA_W'(r_cfg.cell_id);
            REG_CTRL_ID:   prdata = DATA_W'(r_cfg.ctrl_id);
            REG_SHARED_ID: prdata = DATA_W'(r_cfg.shared_id);
            REG_ID_SRC:    prdata = DATA_W'(r_cfg.id_src);
            REG_SHIFT_OFS: prdata = DATA_W'(r_cfg.shift_ofs);
            REG_GHOP_EN:   prdata = DATA_W'(r_cfg.ghop_en);
            REG_SHOP_EN:   prdata = DATA_W'(r_cfg.shop_en);
            REG_LONG_SEQ:  prdata = DATA_W'(r_cfg.long_seq);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

[rtl/ul_rsgh_reduce.sv]
// shared compare-and-subtract unit: remainder and quotient by repeated subtraction
`include "assert_macros.svh"

module ul_rsgh_reduce
    import ul_rsgh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic [VAL_W-1:0]  i_val,
    input  logic [MOD_W-1:0]  i_modulus,
    input  logic              i_step,
    output logic [VAL_W-1:0]  o_val,
    output logic [QUOT_W-1:0] o_quot,
    output logic              o_done
);

    logic [VAL_W-1:0]  r_val;
    logic [MOD_W-1:0]  r_mod;
    logic [QUOT_W-1:0] r_quot;
    logic [VAL_W-1:0]  mod_ext;

    assign mod_ext = VAL_W'(r_mod);
    assign o_done  = (r_val < mod_ext);
    assign o_val   = r_val;
    assign o_quot  = r_quot;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_val  <= i_val;
            r_mod  <= i_modulus;
            r_quot <= '0;
        end else if (i_step && !o_done) begin
            r_val  <= r_val - mod_ext;
            r_quot <= r_quot + QUOT_W'(1);
        end
    end

    `RSGH_ASSERT(a_quot_no_wrap, (i_step && !o_done) |-> (r_quot != '1), "quotient wraps")

endmodule

[rtl/ul_rsgh_gold.sv]
// bit-serial length-31 gold sequence generator, one lfsr step per cycle while warming or running
module ul_rsgh_gold
    import ul_rsgh_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_load,
    input  logic [GOLD_LEN-1:0] i_seed,
    input  logic                i_warm,
    input  logic                i_run,
    output logic                o_bit
);

    logic [GOLD_LEN-1:0] r_x1;
    logic [GOLD_LEN-1:0] r_x2;
    logic                b1;
    logic                b2;

    assign b1    = r_x1[3] ^ r_x1[0];
    assign b2    = r_x2[3] ^ r_x2[2] ^ r_x2[1] ^ r_x2[0];
    assign o_bit = b1 ^ b2;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x1 <= X1_INIT;
            r_x2 <= i_seed;
        end else if (i_run) begin
            r_x1 <= {b1, r_x1[GOLD_LEN-1:1]};
            r_x2 <= {b2, r_x2[GOLD_LEN-1:1]};
        end else if (i_warm) begin
            // x1 starts already advanced, only x2 needs the warm-up
            r_x2 <= {b2, r_x2[GOLD_LEN-1:1]};
        end
    end

endmodule

[rtl/ul_rs_group_sequence_hopping_unit.sv]
// Uplink reference-signal group and sequence hopping unit. For each slot number item it
// returns the sequence group u, base sequence v, hopping pattern f_gh and shift pattern
// f_ss for the identity picked by the identity_source register. One item at a time: an
// item runs from acceptance until o_ready returns. With group or sequence hopping it passes
// through the 1569 warm-up steps and the 8*ns+8 (or ns+1) output steps of the bit-serial
// Gold generator, which advances one step per cycle in those phases; the rest of an item
// goes to the shared subtract unit that reduces the slot, the identity and the sums, one
// subtraction per cycle. o_ready is high only between items; a finished result sits in an
// output register, so the next item can be taken while it waits, and a result that is
// still waiting when the next one is ready holds the block for as long as it waits.
// Registers are to be written through the APB port at byte address 4*index only while the
// block is idle; the block itself does not enforce this.
`include "assert_macros.svh"

module ul_rs_group_sequence_hopping_unit
    import ul_rsgh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [SLOT_W-1:0] i_slot_number,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [OUT_W-1:0]  o_group_number,
    output logic              o_base_sequence,
    output logic [OUT_W-1:0]  o_hop_pattern,
    output logic [OUT_W-1:0]  o_shift_pattern
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_SLOT = 8'b0000_0010,
        S_ID   = 8'b0000_0100,
        S_OFS  = 8'b0000_1000,
        S_WARM = 8'b0001_0000,
        S_RUN  = 8'b0010_0000,
        S_FGH  = 8'b0100_0000,
        S_SUM  = 8'b1000_0000
    } t_state;

    t_cfg   cfg;
    t_state r_state;
    t_state n_state;

    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_start, n_start;
    logic [CNT_W-1:0]  r_last, n_last;
    logic [7:0]        r_byte, n_byte;
    logic [OUT_W-1:0]  r_fss, n_fss;
    logic [OUT_W-1:0]  r_fgh, n_fgh;
    logic [QUOT_W-1:0] r_quot, n_quot;
    logic              r_v, n_v;

    logic              r_ovalid;
    logic [OUT_W-1:0]  r_out_u;
    logic              r_out_v;
    logic [OUT_W-1:0]  r_out_fgh;
    logic [OUT_W-1:0]  r_out_fss;

    logic [ID_W-1:0]     id;
    logic                seq_case;
    logic                accept;
    logic                out_free;
    logic                red_load;
    logic [VAL_W-1:0]    red_load_val;
    logic [MOD_W-1:0]    red_load_mod;
    logic                red_step;
    logic [VAL_W-1:0]    red_val;
    logic [QUOT_W-1:0]   red_quot;
    logic                red_done;
    logic                gold_load;
    logic [GOLD_LEN-1:0] gold_seed;
    logic                gold_bit;
    logic [7:0]          byte_shift;
    logic [NS_W-1:0]     ns;
    logic                emit;

    ul_rsgh_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ul_rsgh_reduce u_reduce (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (red_load),
        .i_val     (red_load_val),
        .i_modulus (red_load_mod),
        .i_step    (red_step),
        .o_val     (red_val),
        .o_quot    (red_quot),
        .o_done    (red_done)
    );

    ul_rsgh_gold u_gold (
        .i_clk  (i_clk),
        .i_load (gold_load),
        .i_seed (gold_seed),
        .i_warm (r_state == S_WARM),
        .i_run  (r_state == S_RUN),
        .o_bit  (gold_bit)
    );

    always_comb begin
        unique case (t_id_src'(cfg.id_src))
            SRC_CTRL:   id = cfg.ctrl_id;
            SRC_SHARED: id = cfg.shared_id;
            default:    id = cfg.cell_id;
        endcase
    end

    assign seq_case   = cfg.long_seq & cfg.shop_en & ~cfg.ghop_en;
    assign o_ready    = (r_state == S_IDLE);
    assign accept     = i_valid & o_ready;
    assign out_free   = ~r_ovalid | i_ready;
    assign byte_shift = {gold_bit, r_byte[7:1]};
    assign ns         = red_val[NS_W-1:0];
    assign red_step   = (r_state == S_SLOT) | (r_state == S_ID) | (r_state == S_OFS)
                      | (r_state == S_FGH) | (r_state == S_SUM);

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_start      = r_start;
        n_last       = r_last;
        n_byte       = r_byte;
        n_fss        = r_fss;
        n_fgh        = r_fgh;
        n_quot       = r_quot;
        n_v          = r_v;
        red_load     = 1'b0;
        red_load_val = '0;
        red_load_mod = MOD_W'(GROUPS);
        gold_load    = 1'b0;
        gold_seed    = '0;
        emit         = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    red_load     = 1'b1;
                    red_load_val = VAL_W'(i_slot_number);
                    red_load_mod = MOD_W'(SLOTS);
                    n_state      = S_SLOT;
                end
            end
            S_SLOT: begin
                if (red_done) begin
                    if (cfg.ghop_en) begin
                        n_start = CNT_W'(ns) << 3;
                        n_last  = (CNT_W'(ns) << 3) + CNT_W'(7);
                    end else begin
                        n_start = CNT_W'(ns);
                        n_last  = CNT_W'(ns);
                    end
                    red_load     = 1'b1;
                    red_load_val = VAL_W'(id);
                    n_state      = S_ID;
                end
            end
            S_ID: begin
                if (red_done) begin
                    n_fss  = red_val[OUT_W-1:0];
                    n_quot = red_quot;
                    n_cnt  = '0;
                    n_byte = '0;
                    red_load = 1'b1;
                    if (seq_case) begin
                        n_fgh        = '0;
                        red_load_val = VAL_W'(red_val[OUT_W-1:0]) + VAL_W'(cfg.shift_ofs);
                        n_state      = S_OFS;
                    end else if (cfg.ghop_en) begin
                        n_v       = 1'b0;
                        gold_load = 1'b1;
                        gold_seed = GOLD_LEN'(red_quot);
                        n_state   = S_WARM;
                    end else begin
                        // no hopping at all: u is just f_ss
                        n_fgh        = '0;
                        n_v          = 1'b0;
                        red_load_val = VAL_W'(red_val[OUT_W-1:0]);
                        n_state      = S_SUM;
                    end
                end
            end
            S_OFS: begin
                if (red_done) begin
                    gold_load = 1'b1;
                    gold_seed = GOLD_LEN'({r_quot, red_val[OUT_W-1:0]});
                    n_state   = S_WARM;
                end
            end
            S_WARM: begin
                if (r_cnt == CNT_W'(WARM_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_RUN;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_RUN: begin
                if (r_cnt >= r_start) begin
                    n_byte = byte_shift;
                end
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == r_last) begin
                    red_load = 1'b1;
                    if (cfg.ghop_en) begin
                        red_load_val = VAL_W'(byte_shift);
                        n_state      = S_FGH;
                    end else begin
                        n_v          = gold_bit;
                        red_load_val = VAL_W'(r_fss);
                        n_state      = S_SUM;
                    end
                end
            end
            S_FGH: begin
                if (red_done) begin
                    n_fgh        = red_val[OUT_W-1:0];
                    red_load     = 1'b1;
                    red_load_val = VAL_W'(red_val[OUT_W-1:0]) + VAL_W'(r_fss);
                    n_state      = S_SUM;
                end
            end
            S_SUM: begin
                if (red_done && out_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt   <= n_cnt;
        r_start <= n_start;
        r_last  <= n_last;
        r_byte  <= n_byte;
        r_fss   <= n_fss;
        r_fgh   <= n_fgh;
        r_quot  <= n_quot;
        r_v     <= n_v;
        if (emit) begin
            r_out_u   <= red_val[OUT_W-1:0];
            r_out_v   <= r_v;
            r_out_fgh <= r_fgh;
            r_out_fss <= r_fss;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_group_number  = r_out_u;
    assign o_base_sequence = r_out_v;
    assign o_hop_pattern   = r_out_fgh;
    assign o_shift_pattern = r_out_fss;

    `RSGH_ASSERT(a_warm_bound, (r_state == S_WARM) |-> (r_cnt < CNT_W'(WARM_STEPS)), "warm-up overrun")
    `RSGH_ASSERT(a_run_bound, (r_state == S_RUN) |-> (r_cnt <= r_last), "gold run overrun")
    `RSGH_ASSERT_NEXT(a_run_exit, (r_state == S_RUN) && (r_cnt == r_last), (r_state == S_FGH) || (r_state == S_SUM), "run did not finish")

endmodule
